@@ src/coined_walk_lattice_step_assert.svh @@
// Assertion macros shared by the coined walk lattice step RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef COINED_WALK_LATTICE_STEP_ASSERT_SVH
`define COINED_WALK_LATTICE_STEP_ASSERT_SVH

`ifndef SYNTHESIS
`define CWLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CWLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CWLS_ASSERT_NOW(label, ante, cons, msg)
`define CWLS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/cwls_pkg.sv @@
// Types and constants for the coined walk lattice step.
// Used by cwls_update and coined_walk_lattice_step; no dependencies.
package cwls_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_R0C0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_R0C1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_R1C0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_R1C1 = 3'd5;

    localparam logic [1:0] MODE_LINE    = 2'd0;
    localparam logic [1:0] MODE_SEGMENT = 2'd1;
    localparam logic [1:0] MODE_CYCLE   = 2'd2;
    localparam logic [1:0] MODE_RSVD    = 2'd3;

    localparam logic [12:0] SITE_COUNT_RST = 13'd4096;
    localparam logic [31:0] COIN_R0C0_RST  = 32'h2D41_0000;
    localparam logic [31:0] COIN_R0C1_RST  = 32'h2D41_0000;
    localparam logic [31:0] COIN_R1C0_RST  = 32'h2D41_0000;
    localparam logic [31:0] COIN_R1C1_RST  = 32'hD2BF_0000;

    typedef struct packed {
        logic signed [15:0] re0;
        logic signed [15:0] im0;
        logic signed [15:0] re1;
        logic signed [15:0] im1;
    } site_amps_t;

    typedef struct packed {
        logic [31:0] r0c0;
        logic [31:0] r0c1;
        logic [31:0] r1c0;
        logic [31:0] r1c1;
    } coin_set_t;

    typedef struct packed {
        site_amps_t  v0;
        site_amps_t  v1;
        logic        row0;
        logic        row1;
        logic [11:0] idx;
        logic        last;
    } job_t;

    typedef struct packed {
        logic signed [15:0] new0_re;
        logic signed [15:0] new0_im;
        logic signed [15:0] new1_re;
        logic signed [15:0] new1_im;
        logic [11:0]        site_index;
        logic               last_result;
    } result_t;

endpackage

@@ src/cwls_update.sv @@
// Coin row update pipeline: registered products, then sum, round and saturate.
// Depends on cwls_pkg and coined_walk_lattice_step_assert.svh.
`include "coined_walk_lattice_step_assert.svh"

module cwls_update
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  cwls_pkg::job_t      job,
    input  cwls_pkg::coin_set_t coin,
    output logic                res_valid,
    input  logic                res_stall,
    output cwls_pkg::result_t   res
);

    logic               s2_vld_reg;
    logic signed [31:0] prod_reg  [2][8];
    logic signed [31:0] prod_next [2][8];
    logic [11:0]        s2_idx_reg;
    logic               s2_last_reg;

    logic               res_vld_reg;
    cwls_pkg::result_t  res_reg;
    cwls_pkg::result_t  res_next;

    logic               s3_ready;

    function automatic logic signed [15:0] round_sat(input logic signed [33:0] acc);
        logic signed [34:0] biased;
        logic signed [20:0] q;
        logic signed [15:0] r;
        biased = 35'(acc) + 35'sd8192;
        q = 21'(biased >>> 14);
        if (q > 21'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (q < -21'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = q[15:0];
        end
        return r;
    endfunction

    assign s3_ready  = !res_vld_reg || !res_stall;
    assign job_ready = !s2_vld_reg || s3_ready;

    always_comb
    begin
        logic                 rsel;
        cwls_pkg::site_amps_t v;
        logic [31:0]          w0;
        logic [31:0]          w1;
        logic signed [15:0]   cr0;
        logic signed [15:0]   ci0;
        logic signed [15:0]   cr1;
        logic signed [15:0]   ci1;
        for (int h = 0; h < 2; h++)
        begin
            rsel = (h == 0) ? job.row0 : job.row1;
            v    = (h == 0) ? job.v0 : job.v1;
            w0   = rsel ? coin.r1c0 : coin.r0c0;
            w1   = rsel ? coin.r1c1 : coin.r0c1;
            cr0  = w0[31:16];
            ci0  = w0[15:0];
            cr1  = w1[31:16];
            ci1  = w1[15:0];
            prod_next[h][0] = cr0 * v.re0;
            prod_next[h][1] = ci0 * v.im0;
            prod_next[h][2] = cr0 * v.im0;
            prod_next[h][3] = ci0 * v.re0;
            prod_next[h][4] = cr1 * v.re1;
            prod_next[h][5] = ci1 * v.im1;
            prod_next[h][6] = cr1 * v.im1;
            prod_next[h][7] = ci1 * v.re1;
        end
    end

    always_comb
    begin
        logic signed [33:0] acc_re [2];
        logic signed [33:0] acc_im [2];
        for (int h = 0; h < 2; h++)
        begin
            acc_re[h] = 34'(prod_reg[h][0]) - 34'(prod_reg[h][1])
                      + 34'(prod_reg[h][4]) - 34'(prod_reg[h][5]);
            acc_im[h] = 34'(prod_reg[h][2]) + 34'(prod_reg[h][3])
                      + 34'(prod_reg[h][6]) + 34'(prod_reg[h][7]);
        end
        res_next.new0_re     = round_sat(acc_re[0]);
        res_next.new0_im     = round_sat(acc_im[0]);
        res_next.new1_re     = round_sat(acc_re[1]);
        res_next.new1_im     = round_sat(acc_im[1]);
        res_next.site_index  = s2_idx_reg;
        res_next.last_result = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                s2_vld_reg <= job_valid;
            end
            if (s3_ready)
            begin
                res_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            prod_reg    <= prod_next;
            s2_idx_reg  <= job.idx;
            s2_last_reg <= job.last;
        end
        if (s2_vld_reg && s3_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    `CWLS_ASSERT_NOW(a_ready_low_full, !job_ready, s2_vld_reg && res_vld_reg,
        "update pipeline refused a job while not full")
    `CWLS_ASSERT_NEXT(a_job_lands, job_valid && job_ready, s2_vld_reg,
        "accepted job did not reach the product stage")
    `CWLS_ASSERT_NEXT(a_product_drains, s2_vld_reg && !res_stall, res_vld_reg,
        "product stage did not move to the result register")

endmodule

@@ src/coined_walk_lattice_step.sv @@
// Top level of the coined walk lattice step: config registers, site window, job issue.
// Depends on cwls_pkg, cwls_update and coined_walk_lattice_step_assert.svh.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------------
//   input   | in_valid / in_stall       | amp0_re amp0_im amp1_re amp1_im links
//   output  | out_valid / out_stall     | new0_re new0_im new1_re new1_im index last
//   config  | cfg_valid / cfg_ready     | cfg_index cfg_data
//
// One site per cycle in steady state while the output is not stalled. The last site
// of a step holds the issue stage in the main and end phases, and the wrap phase in
// cycle mode, since the single coin update pipeline takes one job per cycle at most.
// Reset loads the default coin, mode and site count registers and clears the site counter.
// An output stall holds the pipeline; the input register still takes an item when empty.
`include "coined_walk_lattice_step_assert.svh"

module coined_walk_lattice_step
#(
    parameter int MAX_SITES = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [15:0]             amp0_re,
    input  logic signed [15:0]             amp0_im,
    input  logic signed [15:0]             amp1_re,
    input  logic signed [15:0]             amp1_im,
    input  logic                           right_link_open,
    input  logic                           left_link_open,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             new0_re,
    output logic signed [15:0]             new0_im,
    output logic signed [15:0]             new1_re,
    output logic signed [15:0]             new1_im,
    output logic [11:0]                    site_index,
    output logic                           last_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cwls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam logic [1:0] PH_MAIN = 2'd0;
    localparam logic [1:0] PH_END  = 2'd1;
    localparam logic [1:0] PH_WRAP = 2'd2;

    localparam logic [1:0] LINK_RIGHT = 2'b01;
    localparam logic [1:0] LINK_LEFT  = 2'b10;

    logic [1:0]           lattice_mode_reg;
    logic [12:0]          site_count_reg;
    cwls_pkg::coin_set_t  coin_reg;

    logic                 in_vld_reg;
    logic [1:0]           phase_reg;
    cwls_pkg::site_amps_t cur_amps_reg;
    logic [1:0]           cur_links_reg;

    cwls_pkg::site_amps_t win_amps_reg  [2];
    logic [1:0]           win_links_reg [2];
    cwls_pkg::site_amps_t head_amps_reg [2];
    logic [1:0]           head_links_reg;
    logic [12:0]          site_counter_reg;

    logic                 job_vld_reg;
    cwls_pkg::job_t       job_reg;
    cwls_pkg::job_t       job_next;

    logic [1:0]           mode_eff;
    logic [12:0]          n_eff;
    logic                 is_last;
    logic                 has_job;
    logic                 final_phase;
    logic                 dp_ready;
    logic                 s1_ready;
    logic                 advance;
    logic                 retire;
    logic                 in_accept;
    cwls_pkg::result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lattice_mode_reg <= cwls_pkg::MODE_LINE;
            site_count_reg   <= cwls_pkg::SITE_COUNT_RST;
            coin_reg.r0c0    <= cwls_pkg::COIN_R0C0_RST;
            coin_reg.r0c1    <= cwls_pkg::COIN_R0C1_RST;
            coin_reg.r1c0    <= cwls_pkg::COIN_R1C0_RST;
            coin_reg.r1c1    <= cwls_pkg::COIN_R1C1_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cwls_pkg::CFG_MODE:      lattice_mode_reg <= cfg_data[1:0];
                cwls_pkg::CFG_COUNT:     site_count_reg   <= cfg_data[12:0];
                cwls_pkg::CFG_COIN_R0C0: coin_reg.r0c0    <= cfg_data;
                cwls_pkg::CFG_COIN_R0C1: coin_reg.r0c1    <= cfg_data;
                cwls_pkg::CFG_COIN_R1C0: coin_reg.r1c0    <= cfg_data;
                cwls_pkg::CFG_COIN_R1C1: coin_reg.r1c1    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mode_eff = (lattice_mode_reg == cwls_pkg::MODE_RSVD) ? cwls_pkg::MODE_LINE
                                                                : lattice_mode_reg;

    always_comb
    begin
        if (site_count_reg < 13'd3)
        begin
            n_eff = 13'd3;
        end
        else if (int'(site_count_reg) > MAX_SITES)
        begin
            n_eff = 13'(MAX_SITES);
        end
        else
        begin
            n_eff = site_count_reg;
        end
    end

    assign is_last = ({1'b0, site_counter_reg} + 14'd1) >= {1'b0, n_eff};

    always_comb
    begin
        cwls_pkg::site_amps_t lv;
        cwls_pkg::site_amps_t sv;
        cwls_pkg::site_amps_t rv;
        logic [1:0]           lk;
        logic                 zero;
        lv          = win_amps_reg[0];
        sv          = win_amps_reg[1];
        rv          = cur_amps_reg;
        lk          = win_links_reg[1];
        zero        = 1'b0;
        has_job     = 1'b1;
        final_phase = 1'b1;
        job_next.idx  = 12'(site_counter_reg - 13'd1);
        job_next.last = 1'b0;
        case (phase_reg)
            PH_MAIN:
            begin
                final_phase = !is_last;
                if (site_counter_reg == 13'd0)
                begin
                    has_job = 1'b0;
                end
                else if (site_counter_reg == 13'd1)
                begin
                    job_next.idx = '0;
                    case (mode_eff)
                        cwls_pkg::MODE_LINE:
                        begin
                            zero = 1'b1;
                        end
                        cwls_pkg::MODE_SEGMENT:
                        begin
                            lv = '0;
                            lk = win_links_reg[1] & LINK_RIGHT;
                        end
                        default:
                        begin
                            has_job = 1'b0;
                        end
                    endcase
                end
            end
            PH_END:
            begin
                job_next.idx = site_counter_reg[11:0];
                lv = win_amps_reg[1];
                sv = cur_amps_reg;
                case (mode_eff)
                    cwls_pkg::MODE_LINE:
                    begin
                        zero          = 1'b1;
                        job_next.last = 1'b1;
                    end
                    cwls_pkg::MODE_SEGMENT:
                    begin
                        rv            = '0;
                        lk            = cur_links_reg & LINK_LEFT;
                        job_next.last = 1'b1;
                    end
                    default:
                    begin
                        rv          = head_amps_reg[0];
                        lk          = cur_links_reg;
                        final_phase = 1'b0;
                    end
                endcase
            end
            PH_WRAP:
            begin
                lv            = cur_amps_reg;
                sv            = head_amps_reg[0];
                rv            = head_amps_reg[1];
                lk            = head_links_reg;
                job_next.idx  = '0;
                job_next.last = 1'b1;
            end
            default:
            begin
                has_job = 1'b0;
            end
        endcase
        job_next.row0 = !lk[1];
        job_next.row1 = lk[0];
        job_next.v0   = zero ? '0 : (lk[1] ? lv : sv);
        job_next.v1   = zero ? '0 : (lk[0] ? rv : sv);
    end

    assign s1_ready  = !job_vld_reg || dp_ready;
    assign advance   = in_vld_reg && (!has_job || s1_ready);
    assign retire    = advance && final_phase;
    assign in_stall  = in_vld_reg && !retire;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            phase_reg        <= PH_MAIN;
            site_counter_reg <= '0;
            job_vld_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (retire)
            begin
                in_vld_reg <= 1'b0;
            end
            if (retire)
            begin
                phase_reg        <= PH_MAIN;
                site_counter_reg <= is_last ? '0 : site_counter_reg + 13'd1;
            end
            else if (advance)
            begin
                phase_reg <= (phase_reg == PH_MAIN) ? PH_END : PH_WRAP;
            end
            if (in_vld_reg && has_job && s1_ready)
            begin
                job_vld_reg <= 1'b1;
            end
            else if (dp_ready)
            begin
                job_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_amps_reg.re0 <= amp0_re;
            cur_amps_reg.im0 <= amp0_im;
            cur_amps_reg.re1 <= amp1_re;
            cur_amps_reg.im1 <= amp1_im;
            cur_links_reg    <= {left_link_open, right_link_open};
        end
        if (retire)
        begin
            win_amps_reg[0]  <= win_amps_reg[1];
            win_links_reg[0] <= win_links_reg[1];
            win_amps_reg[1]  <= cur_amps_reg;
            win_links_reg[1] <= cur_links_reg;
            if (site_counter_reg == 13'd0)
            begin
                head_amps_reg[0] <= cur_amps_reg;
                head_links_reg   <= cur_links_reg;
            end
            if (site_counter_reg == 13'd1)
            begin
                head_amps_reg[1] <= cur_amps_reg;
            end
        end
        if (in_vld_reg && has_job && s1_ready)
        begin
            job_reg <= job_next;
        end
    end

    cwls_update u_update
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_vld_reg),
        .job_ready (dp_ready),
        .job       (job_reg),
        .coin      (coin_reg),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (res)
    );

    assign new0_re     = res.new0_re;
    assign new0_im     = res.new0_im;
    assign new1_re     = res.new1_re;
    assign new1_im     = res.new1_im;
    assign site_index  = res.site_index;
    assign last_result = res.last_result;

    `CWLS_ASSERT_NOW(a_phase_needs_item, phase_reg != PH_MAIN, in_vld_reg,
        "issue phase advanced without a held item")
    `CWLS_ASSERT_NEXT(a_counter_wraps, retire && is_last, site_counter_reg == 13'd0,
        "site counter did not return to zero after the last site")
    `CWLS_ASSERT_NOW(a_wrap_cycle_only, phase_reg == PH_WRAP, mode_eff == cwls_pkg::MODE_CYCLE,
        "wrap phase reached outside cycle mode")
    `CWLS_ASSERT_NOW(a_stall_needs_item, in_stall, in_vld_reg,
        "input stalled while the input register is empty")

endmodule
